### hw/rtl/tptb_pkg.sv
// Shared types and constants for the token bucket pacer.
// No dependencies.
package tptb_pkg;

  // event codes carried in the mode field
  localparam logic [1:0] MODE_SENT    = 2'd0;
  localparam logic [1:0] MODE_TIMEOUT = 2'd1;
  localparam logic [1:0] MODE_QUERY   = 2'd2;
  localparam logic [1:0] MODE_APPLIM  = 2'd3;

  localparam int unsigned USEC_PER_SEC = 1000000;
  localparam int unsigned MIN_WAIT_US  = 1000;
  localparam int unsigned BURST_DIV    = 500;

  typedef struct packed {
    logic [1:0]  mode;
    logic [47:0] now_us;
    logic [15:0] byte_count;
    logic [31:0] cwnd_bytes;
    logic [31:0] srtt_us;
    logic        in_slow_start;
    logic        direct_rate_valid;
    logic [39:0] direct_rate;
    logic        timer_busy;
  } in_word_t;

  typedef struct packed {
    logic        may_send;
    logic [31:0] wait_us;
    logic [31:0] budget_bytes;
  } out_word_t;

endpackage

### hw/rtl/tptb_if.sv
// Valid/ready channel interface for pacer words.
// Depends on nothing; the payload type is a parameter.
interface tptb_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/transport_pacing_token_bucket_core.sv
// Token bucket pacer top level: sequencer around a shared serial divider.
// Depends on tptb_pkg, tptb_if and tptb_div.
//
// Usage: one input word per event (sent, timeout, query, app limited) on
// the in_ channel; one result word per event on the out_ channel. The
// cfg_ port writes the initial round-trip time; the user must write it
// only while the block is idle, which the block itself does not enforce.
// A direct rate skips the rate math; otherwise up to five divisions
// run in turn (window over RTT, two-segment fallback, times twelve over
// ten, burst cap, refill or query delay) in one 64-bit serial divider,
// plus shift-add multiplies of one cycle per multiplier bit. One word
// is in flight at a time; in_ready rises again once the result has
// moved into the output register.
// Reset: credit is ten segments, last time and pending credit are zero,
// the initial RTT register returns to 250000 us.
// Stall: a held result sits in the output register; the next input word
// is taken and worked on, and its result waits until the register frees.
module transport_pacing_token_bucket_core #(
  parameter int SEGMENT_BYTES = 1200
) (
  input  logic        clk,
  input  logic        rst_n,
  tptb_if.sink        in_ch,
  tptb_if.source      out_ch,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  localparam logic [31:0] FLOOR_B = 32'(10 * SEGMENT_BYTES);
  localparam logic [63:0] USEC    = 64'(tptb_pkg::USEC_PER_SEC);
  localparam logic [63:0] MIN_R   = 64'(2 * SEGMENT_BYTES) * USEC;
  localparam logic [63:0] MAX32   = 64'hFFFF_FFFF;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_R1    = 4'd1;
  localparam logic [3:0] S_R1W   = 4'd2;
  localparam logic [3:0] S_R2    = 4'd3;
  localparam logic [3:0] S_R2W   = 4'd4;
  localparam logic [3:0] S_SCALE = 4'd5;
  localparam logic [3:0] S_SCW   = 4'd6;
  localparam logic [3:0] S_BUR   = 4'd7;
  localparam logic [3:0] S_BURW  = 4'd8;
  localparam logic [3:0] S_GAIN  = 4'd9;
  localparam logic [3:0] S_GAINW = 4'd10;
  localparam logic [3:0] S_QRY   = 4'd11;
  localparam logic [3:0] S_QRYW  = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;
  localparam logic [3:0] S_MUL   = 4'd14;

  tptb_pkg::in_word_t  w_r;
  tptb_pkg::out_word_t res_r, res_nxt;
  logic [3:0]  st_r, st_nxt, ret_r, ret_nxt;
  logic [31:0] irtt_r;
  logic [31:0] credit_r, credit_nxt;
  logic [47:0] last_r, last_nxt;
  logic [31:0] pend_r, pend_nxt;
  logic [63:0] rate_r, rate_nxt;
  logic [31:0] cap_r, cap_nxt;
  logic [63:0] rtt_r, rtt_nxt;
  logic [31:0] dly_r, dly_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic        rvalid_r, rvalid_nxt;

  // shift-add multiplier: one multiplier bit per cycle, sets mov on carry out
  logic [63:0] ma_r, ma_nxt, mb_r, mb_nxt, mp_r, mp_nxt;
  logic        mov_r, mov_nxt;
  logic [64:0] madd;
  logic [64:0] mshl;

  logic        d_start;
  logic [63:0] d_num, d_den, d_q;
  logic        d_done;

  tptb_div #(.W(64)) u_div (
    .clk(clk), .rst_n(rst_n), .start(d_start), .dividend(d_num),
    .divisor(d_den), .done(d_done), .quotient(d_q)
  );

  logic [47:0] elapsed;
  logic [32:0] sum33;
  logic [31:0] refill_b;
  logic [31:0] gain32;
  logic [31:0] short32;

  assign madd = {1'b0, mp_r} + {1'b0, ma_r};
  assign mshl = {ma_r, 1'b0};
  assign elapsed = (w_r.now_us >= last_r) ? (w_r.now_us - last_r) : '0;

  always_comb begin
    st_nxt     = st_r;
    ret_nxt    = ret_r;
    res_nxt    = res_r;
    credit_nxt = credit_r;
    last_nxt   = last_r;
    pend_nxt   = pend_r;
    rate_nxt   = rate_r;
    cap_nxt    = cap_r;
    rtt_nxt    = rtt_r;
    dly_nxt    = dly_r;
    ma_nxt     = ma_r;
    mb_nxt     = mb_r;
    mp_nxt     = mp_r;
    mov_nxt    = mov_r;
    rvalid_nxt = rvalid_r;
    ovalid_nxt = ovalid_r;
    d_start    = 1'b0;
    d_num      = '0;
    d_den      = 64'd1;
    gain32     = '0;
    sum33      = '0;
    refill_b   = '0;
    short32    = 32'(w_r.byte_count) - credit_r;

    if (ovalid_r && out_ch.ready) ovalid_nxt = 1'b0;

    case (st_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.data.srtt_us != 32'd0) rtt_nxt = 64'(in_ch.data.srtt_us);
          else if (irtt_r != 32'd0)        rtt_nxt = 64'(irtt_r);
          else                             rtt_nxt = 64'd1;
          if (in_ch.data.direct_rate_valid) begin
            rate_nxt = 64'(in_ch.data.direct_rate);
            st_nxt   = S_BUR;
          end else begin
            // cwnd * 1e6 fits 52 bits: serial multiply
            ma_nxt  = 64'(in_ch.data.cwnd_bytes);
            mb_nxt  = USEC;
            mp_nxt  = '0;
            mov_nxt = 1'b0;
            ret_nxt = S_R1;
            st_nxt  = S_MUL;
          end
        end
      end
      S_MUL: begin
        if (mb_r == '0) begin
          st_nxt = ret_r;
        end else begin
          if (mb_r[0]) begin
            mp_nxt = madd[63:0];
            if (madd[64]) mov_nxt = 1'b1;
          end
          if (mb_r[63:1] != '0 && mshl[64]) mov_nxt = 1'b1;
          ma_nxt = mshl[63:0];
          mb_nxt = {1'b0, mb_r[63:1]};
        end
      end
      S_R1: begin
        d_start = 1'b1; d_num = mp_r; d_den = rtt_r; st_nxt = S_R1W;
      end
      S_R1W: if (d_done) begin
        if (d_q == '0) st_nxt = S_R2;
        else begin rate_nxt = d_q; st_nxt = S_SCALE; end
      end
      S_R2: begin
        d_start = 1'b1; d_num = MIN_R; d_den = rtt_r; st_nxt = S_R2W;
      end
      S_R2W: if (d_done) begin
        rate_nxt = d_q; st_nxt = S_SCALE;
      end
      S_SCALE: begin
        if (w_r.in_slow_start) begin
          rate_nxt = {rate_r[62:0], 1'b0};
          st_nxt   = S_BUR;
        end else begin
          // r*12 wraps mod 2^64 as in 64-bit arithmetic; 12 = 8 + 4
          rate_nxt = {rate_r[60:0], 3'b0} + {rate_r[61:0], 2'b0};
          st_nxt   = S_SCW;
        end
      end
      S_SCW: begin
        d_start = 1'b1; d_num = rate_r; d_den = 64'd10; st_nxt = S_BURW;
        ret_nxt = S_SCW;
      end
      S_BUR: begin
        d_start = 1'b1; d_num = rate_r; d_den = 64'(tptb_pkg::BURST_DIV);
        ret_nxt = S_BUR; st_nxt = S_BURW;
      end
      S_BURW: if (d_done) begin
        if (ret_r == S_SCW) begin
          rate_nxt = d_q; st_nxt = S_BUR;
        end else begin
          if (d_q > 64'(FLOOR_B)) cap_nxt = (d_q > MAX32) ? 32'hFFFF_FFFF : d_q[31:0];
          else cap_nxt = FLOOR_B;
          case (w_r.mode)
            tptb_pkg::MODE_QUERY: st_nxt = S_QRY;
            tptb_pkg::MODE_APPLIM: begin
              credit_nxt = FLOOR_B; last_nxt = w_r.now_us; st_nxt = S_DONE;
            end
            default: begin
              ma_nxt  = 64'(elapsed);
              mb_nxt  = rate_r;
              mp_nxt  = '0;
              mov_nxt = 1'b0;
              ret_nxt = S_GAIN;
              st_nxt  = S_MUL;
            end
          endcase
        end
      end
      S_GAIN: begin
        d_start = 1'b1; d_num = mp_r; d_den = USEC; st_nxt = S_GAINW;
      end
      S_GAINW: if (d_done) begin
        if (mov_r || d_q > MAX32) gain32 = 32'hFFFF_FFFF;
        else gain32 = d_q[31:0];
        sum33 = {1'b0, credit_r} + {1'b0, gain32};
        refill_b = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
        if (refill_b > cap_r) refill_b = cap_r;
        if (last_r == '0) refill_b = cap_r;
        if (w_r.mode == tptb_pkg::MODE_SENT) begin
          credit_nxt = (32'(w_r.byte_count) > refill_b) ? '0
                       : refill_b - 32'(w_r.byte_count);
        end else begin
          sum33 = {1'b0, credit_r} + {1'b0, pend_r};
          if (sum33[32]) sum33 = {1'b0, 32'hFFFF_FFFF};
          credit_nxt = (refill_b > sum33[31:0]) ? refill_b : sum33[31:0];
          pend_nxt   = '0;
        end
        last_nxt = w_r.now_us;
        st_nxt   = S_DONE;
      end
      S_QRY: begin
        if (w_r.timer_busy || credit_r >= 32'(w_r.byte_count)) begin
          st_nxt = S_DONE;
        end else begin
          pend_nxt = short32;
          if (rate_r == '0) st_nxt = S_DONE;
          else begin
            // shortfall is below 2^16 here
            d_start = 1'b1; d_num = 64'(short32[15:0]) * USEC; d_den = rate_r;
            st_nxt = S_QRYW;
          end
        end
      end
      S_QRYW: if (d_done) begin
        dly_nxt = (d_q < 64'(tptb_pkg::MIN_WAIT_US))
          ? 32'(tptb_pkg::MIN_WAIT_US)
          : ((d_q > MAX32) ? 32'hFFFF_FFFF : d_q[31:0]);
        rvalid_nxt = 1'b1;
        st_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ovalid_r || out_ch.ready) begin
          if (!rvalid_r) begin
            res_nxt.wait_us  = '0;
            res_nxt.may_send = 1'b0;
            if (w_r.mode == tptb_pkg::MODE_QUERY && !w_r.timer_busy) begin
              if (credit_r >= 32'(w_r.byte_count)) res_nxt.may_send = 1'b1;
              else if (rate_r == '0) res_nxt.wait_us = 32'hFFFF_FFFF;
            end
          end else begin
            res_nxt.wait_us  = dly_r;
            res_nxt.may_send = 1'b0;
          end
          res_nxt.budget_bytes = credit_nxt;
          ovalid_nxt = 1'b1;
          rvalid_nxt = 1'b0;
          st_nxt     = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  assign in_ch.ready  = (st_r == S_IDLE);
  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      ret_r    <= S_IDLE;
      ovalid_r <= 1'b0;
      rvalid_r <= 1'b0;
      irtt_r   <= 32'd250000;
      credit_r <= FLOOR_B;
      last_r   <= '0;
      pend_r   <= '0;
    end else begin
      st_r     <= st_nxt;
      ret_r    <= ret_nxt;
      ovalid_r <= ovalid_nxt;
      rvalid_r <= rvalid_nxt;
      credit_r <= credit_nxt;
      last_r   <= last_nxt;
      pend_r   <= pend_nxt;
      if (cfg_we) irtt_r <= cfg_wdata;
    end
    if (in_ch.valid && st_r == S_IDLE) w_r <= in_ch.data;
    res_r  <= res_nxt;
    rate_r <= rate_nxt;
    cap_r  <= cap_nxt;
    rtt_r  <= rtt_nxt;
    dly_r  <= dly_nxt;
    ma_r   <= ma_nxt;
    mb_r   <= mb_nxt;
    mp_r   <= mp_nxt;
    mov_r  <= mov_nxt;
  end
endmodule

### hw/rtl/tptb_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on nothing.
module tptb_div #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt;
  logic [W:0]    rem_r, rem_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    trial;
  logic [W:0]    diff;

  assign trial = {rem_r[W-1:0], q_r[W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  // shift one dividend bit into the remainder per cycle
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[W]) begin
        rem_nxt = diff;
        q_nxt   = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;
endmodule

### sim/tb.sv
// Testbench for the token bucket pacer core: random and directed event words,
// a scoreboard that predicts each result word, and randomized channel stalls.
// Depends on tptb_pkg, tptb_if and transport_pacing_token_bucket_core.
`timescale 1ns / 100ps

module tb;

  localparam int SEG = 1200;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int HOLD_CYCLES = 1500;
  localparam int N_RANDOM = 1130;

  typedef bit [63:0] u64_t;

  // Predicts pacer results and matches them against the block's output words
  class pacer_scoreboard;
    u64_t start_rtt;
    u64_t credit;
    u64_t last_us;
    u64_t owed;
    tptb_pkg::out_word_t expected_q[$];
    int errors;
    int n_checked;
    int n_refused;
    int n_allowed;

    function new();
      start_rtt = 250000;
      credit = 10 * SEG;
      last_us = 0;
      owed = 0;
      errors = 0;
      n_checked = 0;
      n_refused = 0;
      n_allowed = 0;
    endfunction

    function u64_t sat32(u64_t v);
      return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
    endfunction

    function u64_t pace_rate(tptb_pkg::in_word_t w);
      u64_t rtt;
      u64_t r;
      if (w.direct_rate_valid) return u64_t'(w.direct_rate);
      rtt = (w.srtt_us != 0) ? u64_t'(w.srtt_us) : start_rtt;
      if (rtt == 0) rtt = 1;
      r = u64_t'(w.cwnd_bytes) * u64_t'(tptb_pkg::USEC_PER_SEC) / rtt;
      if (r == 0) r = u64_t'(2 * SEG) * u64_t'(tptb_pkg::USEC_PER_SEC) / rtt;
      if (w.in_slow_start) r = r * 2;
      else r = r * 12 / 10;
      return r;
    endfunction

    function u64_t refilled(u64_t now_us, u64_t rate);
      u64_t cap;
      u64_t elapsed;
      u64_t gain;
      u64_t b;
      cap = rate / u64_t'(tptb_pkg::BURST_DIV);
      if (cap < 10 * SEG) cap = 10 * SEG;
      cap = sat32(cap);
      if (last_us == 0) return cap;
      elapsed = (now_us >= last_us) ? now_us - last_us : 0;
      if (rate != 0 && elapsed > 64'hFFFF_FFFF_FFFF_FFFF / rate) gain = 64'hFFFF_FFFF;
      else gain = sat32(elapsed * rate / u64_t'(tptb_pkg::USEC_PER_SEC));
      b = sat32(credit + gain);
      return (b < cap) ? b : cap;
    endfunction

    function void write_rtt(logic [31:0] v);
      start_rtt = u64_t'(v);
    endfunction

    // Accepted input word: advance the model and queue its result
    function void note_input(tptb_pkg::in_word_t w);
      u64_t rate;
      u64_t b;
      u64_t sum;
      u64_t shortfall;
      u64_t dly;
      tptb_pkg::out_word_t o;
      rate = pace_rate(w);
      o.may_send = 1'b0;
      dly = 0;
      case (w.mode)
        tptb_pkg::MODE_SENT: begin
          b = refilled(u64_t'(w.now_us), rate);
          credit = (u64_t'(w.byte_count) > b) ? 0 : b - u64_t'(w.byte_count);
          last_us = u64_t'(w.now_us);
        end
        tptb_pkg::MODE_TIMEOUT: begin
          b = refilled(u64_t'(w.now_us), rate);
          sum = sat32(credit + owed);
          credit = (b > sum) ? b : sum;
          owed = 0;
          last_us = u64_t'(w.now_us);
        end
        tptb_pkg::MODE_QUERY: begin
          if (!w.timer_busy) begin
            if (credit >= u64_t'(w.byte_count)) begin
              o.may_send = 1'b1;
              n_allowed++;
            end else begin
              shortfall = u64_t'(w.byte_count) - credit;
              if (rate == 0) dly = 64'hFFFF_FFFF;
              else begin
                dly = shortfall * u64_t'(tptb_pkg::USEC_PER_SEC) / rate;
                if (dly < u64_t'(tptb_pkg::MIN_WAIT_US))
                  dly = u64_t'(tptb_pkg::MIN_WAIT_US);
                dly = sat32(dly);
              end
              owed = shortfall;
              n_refused++;
            end
          end
        end
        default: begin
          credit = 10 * SEG;
          last_us = u64_t'(w.now_us);
        end
      endcase
      o.wait_us = dly[31:0];
      o.budget_bytes = credit[31:0];
      expected_q.push_back(o);
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    // Accepted result word: compare with the oldest prediction
    task check_result(tptb_pkg::out_word_t got);
      tptb_pkg::out_word_t exp_w;
      if (expected_q.size() == 0) begin
        report("result word with no prediction pending");
        return;
      end
      exp_w = expected_q.pop_front();
      n_checked++;
      if (got.may_send !== exp_w.may_send)
        report($sformatf("word %0d may_send %b want %b", n_checked, got.may_send,
                         exp_w.may_send));
      if (got.wait_us !== exp_w.wait_us)
        report($sformatf("word %0d wait_us %0d want %0d", n_checked, got.wait_us,
                         exp_w.wait_us));
      if (got.budget_bytes !== exp_w.budget_bytes)
        report($sformatf("word %0d budget_bytes %0d want %0d", n_checked,
                         got.budget_bytes, exp_w.budget_bytes));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  bit hold_req = 1'b0;
  bit dense = 1'b0;
  int idle_cycles = 0;
  int n_sent = 0;
  u64_t clock_us = 0;

  tptb_if #(.T(tptb_pkg::in_word_t)) in_ch ();
  tptb_if #(.T(tptb_pkg::out_word_t)) out_ch ();

  pacer_scoreboard sb = new();

  transport_pacing_token_bucket_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // Gap length: mostly none or short, now and then long
  function int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (dense || p < 55) return 0;
    if (p < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 90);
  endfunction

  // Offer one word and wait for the handshake
  task send_word(tptb_pkg::in_word_t w);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(w);
    n_sent++;
  endtask

  task drop_valid();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for the pipeline to drain, then write the RTT register
  task write_rtt(logic [31:0] v);
    drop_valid();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    sb.write_rtt(v);
    cfg_we <= 1'b0;
  endtask

  function tptb_pkg::in_word_t make_word(logic [1:0] m, u64_t now_us, int bytes);
    tptb_pkg::in_word_t w;
    w = '0;
    w.mode = m;
    w.now_us = now_us[47:0];
    w.byte_count = bytes[15:0];
    w.cwnd_bytes = 32'd14400;
    w.srtt_us = 32'd20000;
    return w;
  endfunction

  // Random word: mostly forward time steps with a valid congestion state
  function tptb_pkg::in_word_t rand_word();
    tptb_pkg::in_word_t w;
    int p;
    w = '0;
    w.mode = 2'($urandom_range(0, 3));
    p = $urandom_range(0, 99);
    if (p < 50) clock_us += u64_t'($urandom_range(0, 3000));
    else if (p < 80) clock_us += u64_t'($urandom_range(0, 40));
    else if (p < 88) clock_us += {$urandom, $urandom} & 64'hF_FFFF_FFFF;
    else if (p < 93) clock_us -= u64_t'($urandom_range(0, 500));
    else if (p < 96) clock_us = 0;
    else clock_us = {$urandom, $urandom};
    clock_us &= 64'hFFFF_FFFF_FFFF;
    w.now_us = clock_us[47:0];
    p = $urandom_range(0, 99);
    if (p < 60) w.byte_count = 16'($urandom_range(0, 3 * SEG));
    else if (p < 90) w.byte_count = 16'($urandom);
    else w.byte_count = (p < 95) ? 16'hFFFF : 16'h0;
    p = $urandom_range(0, 99);
    if (p < 50) w.cwnd_bytes = $urandom_range(0, 2000000);
    else if (p < 60) w.cwnd_bytes = 0;
    else w.cwnd_bytes = $urandom;
    p = $urandom_range(0, 99);
    if (p < 50) w.srtt_us = $urandom_range(1, 500000);
    else if (p < 70) w.srtt_us = 0;
    else w.srtt_us = $urandom;
    w.in_slow_start = 1'($urandom_range(0, 1));
    w.direct_rate_valid = ($urandom_range(0, 3) == 0);
    p = $urandom_range(0, 99);
    if (p < 40) w.direct_rate = 40'($urandom_range(0, 100000000));
    else if (p < 50) w.direct_rate = 0;
    else w.direct_rate = 40'({$urandom, $urandom});
    w.timer_busy = ($urandom_range(0, 4) == 0);
    return w;
  endfunction

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        stall = gap_len();
        out_ch.ready <= (stall == 0);
      end
    end
  end

  // Watchdog on cycles with no word moving on either channel
  initial begin
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", idle_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    tptb_pkg::in_word_t w;
    logic [31:0] rtt_set [5];
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    rtt_set[0] = 32'd0;
    rtt_set[1] = 32'd1;
    rtt_set[2] = 32'hFFFF_FFFF;
    rtt_set[3] = 32'd40000;
    rtt_set[4] = $urandom;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: first event at time zero, refills, queries, edge fields
    send_word(make_word(tptb_pkg::MODE_QUERY, 0, 100));
    send_word(make_word(tptb_pkg::MODE_SENT, 0, 5000));
    send_word(make_word(tptb_pkg::MODE_SENT, 1000, 65535));
    send_word(make_word(tptb_pkg::MODE_QUERY, 1100, 65535));
    send_word(make_word(tptb_pkg::MODE_TIMEOUT, 1200, 0));
    send_word(make_word(tptb_pkg::MODE_QUERY, 1300, 0));
    w = make_word(tptb_pkg::MODE_QUERY, 1400, 65535);
    w.timer_busy = 1'b1;
    send_word(w);
    send_word(make_word(tptb_pkg::MODE_APPLIM, 1500, 0));
    send_word(make_word(tptb_pkg::MODE_SENT, 900, 12000));
    w = make_word(tptb_pkg::MODE_QUERY, 950, 4000);
    w.direct_rate_valid = 1'b1;
    w.direct_rate = '0;
    send_word(w);
    w = make_word(tptb_pkg::MODE_TIMEOUT, 5000, 0);
    w.direct_rate_valid = 1'b1;
    w.direct_rate = '0;
    send_word(w);
    w = make_word(tptb_pkg::MODE_SENT, 48'hFFFF_FFFF_FFFF, 1);
    w.direct_rate_valid = 1'b1;
    w.direct_rate = 40'hFF_FFFF_FFFF;
    send_word(w);
    w = make_word(tptb_pkg::MODE_SENT, 10, 200);
    send_word(w);
    w = make_word(tptb_pkg::MODE_SENT, 48'hFFFF_FFFF_FFFF, 0);
    w.direct_rate_valid = 1'b1;
    w.direct_rate = 40'hFF_FFFF_FFFF;
    send_word(w);
    w = make_word(tptb_pkg::MODE_SENT, 20, 65535);
    w.cwnd_bytes = '0;
    w.srtt_us = 32'hFFFF_FFFF;
    send_word(w);
    w = make_word(tptb_pkg::MODE_QUERY, 30, 65535);
    w.cwnd_bytes = 32'hFFFF_FFFF;
    w.srtt_us = 32'd1;
    w.in_slow_start = 1'b1;
    send_word(w);
    w = make_word(tptb_pkg::MODE_QUERY, 40, 65535);
    w.srtt_us = '0;
    send_word(w);
    w = make_word(tptb_pkg::MODE_APPLIM, 48'h0, 16'hFFFF);
    w.cwnd_bytes = 32'hFFFF_FFFF;
    w.srtt_us = 32'hFFFF_FFFF;
    w.in_slow_start = 1'b1;
    w.timer_busy = 1'b1;
    send_word(w);
    w = make_word(tptb_pkg::MODE_SENT, 50, 1);
    send_word(w);

    // Random phases, one per RTT register setting
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) write_rtt(rtt_set[ph - 1]);
      if (ph == 0) begin
        w = make_word(tptb_pkg::MODE_QUERY, 60, 65535);
        w.srtt_us = '0;
        w.cwnd_bytes = '0;
        send_word(w);
      end
      for (int i = 0; i < N_RANDOM / 6; i++) begin
        dense = (i >= 60 && i < 100);
        if (ph == 1 && i == 50) hold_req = 1'b1;
        if (ph == 2 && i == 80) begin
          drop_valid();
          while (sb.expected_q.size() != 0) @(posedge clk);
        end
        send_word(rand_word());
      end
    end
    dense = 1'b0;
    drop_valid();

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    $display("Ran %0d event words through six RTT settings; %0d results checked,",
             n_sent, sb.n_checked);
    $display("%0d queries allowed, %0d refused with a delay", sb.n_allowed, sb.n_refused);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
